// ----- design/spq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg: shared types and codes for the sorted priority queue
// Operation codes, status codes, field widths and the cell control word.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int DATA_W = 32;
	localparam int MODE_W = 2;
	localparam int STAT_W = 2;
	localparam int FILL_W = 5;

	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_PEEK   = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic                     ins_en;
		logic                     rem_en;
		logic signed [DATA_W-1:0] new_value;
		logic signed [DATA_W-1:0] new_priority;
	} cell_ctrl_t;

endpackage

// ----- design/spq_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted queue
// Holds one entry; on insert it loads the new word or its lower neighbor's,
// on remove it loads its upper neighbor's.
// ----------------------------------------------------------------------------
module spq_cell (
	input  logic                             clk,
	input  spq_pkg::cell_ctrl_t              ctrl,
	input  logic                             occ,
	input  logic                             prev_m,
	input  logic signed [spq_pkg::DATA_W-1:0] prev_value,
	input  logic signed [spq_pkg::DATA_W-1:0] prev_priority,
	input  logic signed [spq_pkg::DATA_W-1:0] next_value,
	input  logic signed [spq_pkg::DATA_W-1:0] next_priority,
	output logic                             m,
	output logic signed [spq_pkg::DATA_W-1:0] value,
	output logic signed [spq_pkg::DATA_W-1:0] prio
);
	import spq_pkg::*;

	logic signed [DATA_W-1:0] value_q;
	logic signed [DATA_W-1:0] priority_q;

	// slot at or above the insert point
	assign m = !occ || (priority_q > ctrl.new_priority);

	always_ff @(posedge clk) begin
		if (ctrl.ins_en) begin
			if (m && !prev_m) begin
				value_q    <= ctrl.new_value;
				priority_q <= ctrl.new_priority;
			end else if (m && prev_m) begin
				value_q    <= prev_value;
				priority_q <= prev_priority;
			end
		end else if (ctrl.rem_en) begin
			value_q    <= next_value;
			priority_q <= next_priority;
		end
	end

	assign value = value_q;
	assign prio  = priority_q;

endmodule

// ----- design/sorted_priority_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue: priority queue held in a chain of cells
// Up to CAPACITY entries kept sorted; remove and peek act on the entry
// with the lowest priority value, oldest first among equals.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a word is taken on a rising edge with start high and
//   busy low. busy stays low, so a command can be issued every cycle.
//   mode selects insert, remove or peek; item_value and item_priority are
//   read by insert only.
//   Result channel: one word per command, shown for exactly one cycle with
//   done high, on the cycle after the command is taken.
//   Throughput is one command per cycle: every cell compares its priority
//   with the incoming one in parallel and shifts by one slot in that cycle.
//   Slot 0 holds the lowest-value entry, so remove/peek read a fixed cell.
//   Reset empties the queue (entry count to zero) and clears done; cell
//   contents and result registers are not reset. The receiver cannot stall the result channel.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
	parameter int CAPACITY = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [spq_pkg::MODE_W-1:0]        mode,
	input  logic signed [spq_pkg::DATA_W-1:0] item_value,
	input  logic signed [spq_pkg::DATA_W-1:0] item_priority,
	output logic                              done,
	output logic signed [spq_pkg::DATA_W-1:0] out_value,
	output logic signed [spq_pkg::DATA_W-1:0] out_priority,
	output logic                              out_valid,
	output logic [spq_pkg::STAT_W-1:0]        status,
	output logic [spq_pkg::FILL_W-1:0]        fill_level
);
	import spq_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         count_d;
	logic                     accept;
	logic                     full;
	logic                     empty;
	logic                     do_ins;
	logic                     do_rem;
	logic                     do_read;
	cell_ctrl_t               ctrl;

	logic [CAPACITY-1:0]      occ;
	logic [CAPACITY-1:0]      m_vec;
	logic signed [DATA_W-1:0] cell_value [CAPACITY];
	logic signed [DATA_W-1:0] cell_priority [CAPACITY];

	logic                     done_q;
	logic signed [DATA_W-1:0] out_value_q;
	logic signed [DATA_W-1:0] out_priority_q;
	logic                     out_valid_q;
	logic [STAT_W-1:0]        status_q;
	logic [FILL_W-1:0]        fill_level_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = (count_q == CNT_W'(CAPACITY));
	assign empty  = (count_q == '0);

	assign do_ins  = accept && (mode == MODE_INSERT) && !full;
	assign do_read = accept && ((mode == MODE_REMOVE) || (mode == MODE_PEEK)) && !empty;
	assign do_rem  = accept && (mode == MODE_REMOVE) && !empty;

	assign ctrl.ins_en       = do_ins;
	assign ctrl.rem_en       = do_rem;
	assign ctrl.new_value    = item_value;
	assign ctrl.new_priority = item_priority;

	always_comb begin
		count_d = count_q;
		if (do_ins)
			count_d = count_q + CNT_W'(1);
		else if (do_rem)
			count_d = count_q - CNT_W'(1);
	end

	genvar j;
	generate
		for (j = 0; j < CAPACITY; j++) begin : g_cell
			logic                     pm;
			logic signed [DATA_W-1:0] pv;
			logic signed [DATA_W-1:0] pp;
			logic signed [DATA_W-1:0] nv;
			logic signed [DATA_W-1:0] np;

			assign occ[j] = (count_q > CNT_W'(j));

			if (j == 0) begin : g_first
				assign pm = 1'b0;
				assign pv = item_value;
				assign pp = item_priority;
			end else begin : g_mid
				assign pm = m_vec[j-1];
				assign pv = cell_value[j-1];
				assign pp = cell_priority[j-1];
			end

			if (j == CAPACITY - 1) begin : g_last
				assign nv = cell_value[j];
				assign np = cell_priority[j];
			end else begin : g_inner
				assign nv = cell_value[j+1];
				assign np = cell_priority[j+1];
			end

			spq_cell u_cell (
				.clk           (clk),
				.ctrl          (ctrl),
				.occ           (occ[j]),
				.prev_m        (pm),
				.prev_value    (pv),
				.prev_priority (pp),
				.next_value    (nv),
				.next_priority (np),
				.m             (m_vec[j]),
				.value         (cell_value[j]),
				.prio          (cell_priority[j])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_d;
			done_q  <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_value_q    <= do_read ? cell_value[0] : '0;
			out_priority_q <= do_read ? cell_priority[0] : '0;
			out_valid_q    <= do_read;
			fill_level_q   <= FILL_W'(count_d);
			if ((mode == MODE_INSERT) && full)
				status_q <= ST_FULL;
			else if (((mode == MODE_REMOVE) || (mode == MODE_PEEK)) && empty)
				status_q <= ST_EMPTY;
			else
				status_q <= ST_OK;
		end
	end

	assign done         = done_q;
	assign out_value    = out_value_q;
	assign out_priority = out_priority_q;
	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign fill_level   = fill_level_q;

endmodule

// ----- design/spq_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_checker: port-level checks for the sorted priority queue
// Watches the command and result channels of the top level.
// ----------------------------------------------------------------------------
module spq_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic                              done,
	input logic signed [spq_pkg::DATA_W-1:0] out_value,
	input logic signed [spq_pkg::DATA_W-1:0] out_priority,
	input logic                              out_valid,
	input logic [spq_pkg::STAT_W-1:0]        status,
	input logic [spq_pkg::FILL_W-1:0]        fill_level
);
	import spq_pkg::*;

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("command word taken but no result word");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> !done)
		else $error("result word without a command");

	a_valid_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && out_valid) |-> (status == ST_OK))
		else $error("entry reported with error status");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !out_valid) |-> (out_value == '0 && out_priority == '0))
		else $error("payload not zero without entry");

	a_empty_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_EMPTY) |-> (fill_level == '0))
		else $error("empty status with nonzero fill level");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for sorted_priority_queue
// Sends insert, remove, peek and unused-mode words, with random gaps outside the
// back-to-back phase, runs each accepted word through a shadow sorted queue, and
// compares every result word field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module testbench;
	import spq_pkg::*;

	localparam int CAPACITY = 16;
	localparam int CYCLE_LIMIT = 60000;
	localparam int MAX_REPORTS = 60;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam logic signed [DATA_W-1:0] PRIO_MIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] PRIO_MAX = 32'sh7fff_ffff;

	typedef struct {
		logic signed [DATA_W-1:0] val;
		logic signed [DATA_W-1:0] prio;
		logic                     valid;
		logic [STAT_W-1:0]        stat;
		logic [FILL_W-1:0]        fill;
	} queue_word_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic [MODE_W-1:0]        mode = MODE_INSERT;
	logic signed [DATA_W-1:0] item_value = '0;
	logic signed [DATA_W-1:0] item_priority = '0;
	logic                     busy;
	logic                     done;
	logic signed [DATA_W-1:0] out_value;
	logic signed [DATA_W-1:0] out_priority;
	logic                     out_valid;
	logic [STAT_W-1:0]        status;
	logic [FILL_W-1:0]        fill_level;

	logic signed [DATA_W-1:0] shadow_val [CAPACITY];
	logic signed [DATA_W-1:0] shadow_prio [CAPACITY];
	int                       shadow_count = 0;
	queue_word_t              pending_results[$];
	int                       error_count = 0;
	int                       cycle_count = 0;
	bit                       no_idle = 1'b0;

	sorted_priority_queue #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.item_value(item_value),
		.item_priority(item_priority),
		.done(done),
		.out_value(out_value),
		.out_priority(out_priority),
		.out_valid(out_valid),
		.status(status),
		.fill_level(fill_level)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	// shadow of the sorted array: highest priority value at slot 0, lowest at the tail
	function automatic queue_word_t apply_queue_op(input logic [MODE_W-1:0] op,
			input logic signed [DATA_W-1:0] v, input logic signed [DATA_W-1:0] p);
		queue_word_t r;
		int pos;
		r.val = '0;
		r.prio = '0;
		r.valid = 1'b0;
		r.stat = ST_OK;
		case (op)
			MODE_INSERT: begin
				if (shadow_count >= CAPACITY) begin
					r.stat = ST_FULL;
				end else begin
					pos = shadow_count;
					for (int i = 0; i < shadow_count; i++) begin
						if (shadow_prio[i] <= p) begin
							pos = i;
							break;
						end
					end
					for (int i = shadow_count; i > pos; i--) begin
						shadow_val[i] = shadow_val[i-1];
						shadow_prio[i] = shadow_prio[i-1];
					end
					shadow_val[pos] = v;
					shadow_prio[pos] = p;
					shadow_count++;
				end
			end
			MODE_REMOVE, MODE_PEEK: begin
				if (shadow_count == 0) begin
					r.stat = ST_EMPTY;
				end else begin
					r.val = shadow_val[shadow_count-1];
					r.prio = shadow_prio[shadow_count-1];
					r.valid = 1'b1;
					if (op == MODE_REMOVE)
						shadow_count--;
				end
			end
			default: ;
		endcase
		r.fill = FILL_W'(shadow_count);
		return r;
	endfunction

	task automatic send_word(input logic [MODE_W-1:0] op,
			input logic signed [DATA_W-1:0] v, input logic signed [DATA_W-1:0] p);
		if (!no_idle) begin
			while ($urandom_range(99) < 28) begin
				start <= 1'b0;
				@(posedge clk);
			end
		end
		start <= 1'b1;
		mode <= op;
		item_value <= v;
		item_priority <= p;
		do @(posedge clk); while (busy);
		pending_results.push_back(apply_queue_op(op, v, p));
	endtask

	task automatic check_field(input string name, input logic [DATA_W-1:0] exp_v,
			input logic [DATA_W-1:0] act_v);
		if (exp_v !== act_v) begin
			error_count++;
			if (error_count <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0h, actual %0h",
					$time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk) begin
		queue_word_t exp_w;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				error_count++;
				if (error_count <= MAX_REPORTS)
					$display("%0t: unexpected result word, expected none, actual %0h/%0h",
						$time, out_value, out_priority);
			end else begin
				exp_w = pending_results.pop_front();
				check_field("out_value", exp_w.val, out_value);
				check_field("out_priority", exp_w.prio, out_priority);
				check_field("out_valid", DATA_W'(exp_w.valid), DATA_W'(out_valid));
				check_field("status", DATA_W'(exp_w.stat), DATA_W'(status));
				check_field("fill_level", DATA_W'(exp_w.fill), DATA_W'(fill_level));
			end
		end
	end

	function automatic logic signed [DATA_W-1:0] pick_priority(input bit narrow);
		if (narrow)
			return DATA_W'(int'($urandom_range(6)) - 3);
		case ($urandom_range(9))
			0: return PRIO_MIN;
			1: return PRIO_MAX;
			2: return '0;
			3: return -1;
			default: return $urandom;
		endcase
	endfunction

	task automatic test_empty_queue();
		send_word(MODE_REMOVE, 32'sd5, 32'sd5);
		send_word(MODE_PEEK, -1, -1);
		send_word(MODE_UNUSED, PRIO_MAX, PRIO_MIN);
	endtask

	task automatic test_extremes_and_ties();
		send_word(MODE_INSERT, PRIO_MAX, PRIO_MAX);
		send_word(MODE_INSERT, PRIO_MIN, PRIO_MIN);
		send_word(MODE_INSERT, '0, '0);
		send_word(MODE_INSERT, -1, -1);
		send_word(MODE_INSERT, 32'sd11, '0);
		send_word(MODE_INSERT, 32'sd22, -1);
		send_word(MODE_PEEK, '0, '0);
		send_word(MODE_UNUSED, -1, -1);
		repeat (6) send_word(MODE_REMOVE, '0, '0);
		send_word(MODE_REMOVE, '0, '0);
		send_word(MODE_PEEK, '0, '0);
	endtask

	task automatic test_full_queue();
		bit narrow;
		narrow = $urandom_range(1);
		while (shadow_count < CAPACITY)
			send_word(MODE_INSERT, $urandom, pick_priority(narrow));
		send_word(MODE_INSERT, $urandom, pick_priority(1'b0));
		send_word(MODE_INSERT, PRIO_MIN, PRIO_MIN);
		send_word(MODE_PEEK, $urandom, $urandom);
		send_word(MODE_UNUSED, $urandom, $urandom);
		while (shadow_count > 0)
			send_word(MODE_REMOVE, $urandom, $urandom);
		send_word(MODE_PEEK, $urandom, $urandom);
	endtask

	task automatic random_phase(input int words, input int insert_pct, input bit narrow);
		int r;
		repeat (words) begin
			r = $urandom_range(99);
			if (r < 2)
				send_word(MODE_UNUSED, $urandom, $urandom);
			else if (r < 2 + insert_pct)
				send_word(MODE_INSERT, $urandom, pick_priority(narrow));
			else if ($urandom_range(99) < 70)
				send_word(MODE_REMOVE, $urandom, $urandom);
			else
				send_word(MODE_PEEK, $urandom, $urandom);
		end
	endtask

	task automatic test_back_to_back();
		no_idle = 1'b1;
		random_phase(100, 60, 1'b0);
		random_phase(100, 35, 1'b1);
		no_idle = 1'b0;
	endtask

	task automatic test_random_traffic();
		int sent;
		int words;
		int pct;
		sent = 0;
		while (sent < 1000) begin
			words = $urandom_range(40, 120);
			case ($urandom_range(3))
				0: pct = 15;
				1: pct = 85;
				2: pct = 50;
				default: pct = $urandom_range(20, 80);
			endcase
			random_phase(words, pct, $urandom_range(99) < 40);
			sent += words;
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_queue();
		test_extremes_and_ties();
		test_full_queue();
		test_back_to_back();
		test_random_traffic();
		test_full_queue();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (error_count == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

// ----- sorted_priority_queue.f -----
design/spq_pkg.sv
design/spq_cell.sv
design/sorted_priority_queue.sv
design/spq_checker.sv
test/testbench.sv
